[sv/ukt_pkg.sv]
// shared types and defaults for the unsorted key table
package ukt_pkg;

  localparam int DEF_CAPACITY   = 64;
  localparam int DEF_KEY_BITS   = 16;
  localparam int DEF_VALUE_BITS = 32;

  typedef enum logic [2:0] {
    REQ_INSERT       = 3'd0,
    REQ_RETRIEVE     = 3'd1,
    REQ_DEL_FIRST    = 3'd2,
    REQ_DEL_ALL      = 3'd3,
    REQ_RESET_CURSOR = 3'd4,
    REQ_GET_NEXT     = 3'd5
  } ukt_req_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_PAST_END  = 2'd3
  } ukt_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MOVE,
    ST_NEXT
  } ukt_state_t;

endpackage

[sv/ukt_mem.sv]
// single-port-write, single-port-read entry memory with registered read data
module ukt_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[sv/unsorted_key_table.sv]
// unsorted key/value table with linear search over an entry memory
//
//   channel   ports                                   handshake
//   -------   -------------------------------------   ---------------------------
//   request   in_req_type in_search_key in_entry_value start high and busy low
//   result    out_status out_found out_result_key     out_valid, one cycle, no
//             out_result_value out_entry_count         back-pressure
//             out_is_full
//
// insert, reset cursor and unused codes give their result the cycle after accept;
//   get next reads the cursor's entry, then registers it; past end needs no read
// retrieve and deletes scan the entry memory one read a cycle, pipelined against
//   the compare, pausing while a delete refills a matched slot from the tail
// reset clears count, cursor and control only; the entry memory needs no clearing
// one item at a time: busy stays high until its result is strobed out, and a new
//   item may be accepted in the cycle its predecessor's result is shown
module unsorted_key_table #(
  parameter int CAPACITY   = ukt_pkg::DEF_CAPACITY,
  parameter int KEY_BITS   = ukt_pkg::DEF_KEY_BITS,
  parameter int VALUE_BITS = ukt_pkg::DEF_VALUE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    in_req_type,
  input  logic [KEY_BITS-1:0]           in_search_key,
  input  logic [VALUE_BITS-1:0]         in_entry_value,
  output logic                          out_valid,
  output logic [1:0]                    out_status,
  output logic                          out_found,
  output logic [KEY_BITS-1:0]           out_result_key,
  output logic [VALUE_BITS-1:0]         out_result_value,
  output logic [$clog2(CAPACITY+1)-1:0] out_entry_count,
  output logic                          out_is_full
);
  import ukt_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = KEY_BITS + VALUE_BITS;

  // control state
  ukt_state_t            state_r,   state_nxt;
  ukt_req_t              req_r,     req_nxt;
  logic [KEY_BITS-1:0]   key_r,     key_nxt;
  logic [CW-1:0]         count_r,   count_nxt;
  logic [CW-1:0]         cursor_r,  cursor_nxt;
  logic [CW-1:0]         idx_r,     idx_nxt;     // next slot to read in a scan
  logic [AW-1:0]         cmp_idx_r, cmp_idx_nxt; // slot whose data sits on the read port
  logic                  pend_r,    pend_nxt;    // read data valid for compare
  logic                  found_r,   found_nxt;   // some entry matched in this scan

  // result registers
  logic                  valid_r,   valid_nxt;
  ukt_status_t           status_r,  status_nxt;
  logic                  rfound_r,  rfound_nxt;
  logic [KEY_BITS-1:0]   rkey_r,    rkey_nxt;
  logic [VALUE_BITS-1:0] rval_r,    rval_nxt;

  // memory port
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [EW-1:0]         mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic [EW-1:0]         mem_rdata;

  logic [KEY_BITS-1:0]   rd_key;
  logic [VALUE_BITS-1:0] rd_val;
  logic [CW-1:0]         last;

  assign rd_key = mem_rdata[EW-1:VALUE_BITS];
  assign rd_val = mem_rdata[VALUE_BITS-1:0];
  assign last   = count_r - CW'(1);

  ukt_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (EW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      cursor_r <= '0;
      pend_r   <= 1'b0;
      found_r  <= 1'b0;
      valid_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      cursor_r <= cursor_nxt;
      pend_r   <= pend_nxt;
      found_r  <= found_nxt;
      valid_r  <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    key_r     <= key_nxt;
    idx_r     <= idx_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    status_r  <= status_nxt;
    rfound_r  <= rfound_nxt;
    rkey_r    <= rkey_nxt;
    rval_r    <= rval_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    req_nxt     = req_r;
    key_nxt     = key_r;
    count_nxt   = count_r;
    cursor_nxt  = cursor_r;
    idx_nxt     = idx_r;
    cmp_idx_nxt = cmp_idx_r;
    pend_nxt    = pend_r;
    found_nxt   = found_r;
    valid_nxt   = 1'b0;
    status_nxt  = status_r;
    rfound_nxt  = rfound_r;
    rkey_nxt    = rkey_r;
    rval_nxt    = rval_r;
    mem_we      = 1'b0;
    mem_waddr   = count_r[AW-1:0];
    mem_wdata   = {in_search_key, in_entry_value};
    mem_raddr   = idx_r[AW-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          // default result: ok with empty payload
          status_nxt = STAT_OK;
          rfound_nxt = 1'b0;
          rkey_nxt   = '0;
          rval_nxt   = '0;
          unique case (in_req_type) inside
            REQ_INSERT: begin
              valid_nxt = 1'b1;
              if (count_r < CW'(CAPACITY)) begin
                // append at the tail slot
                mem_we    = 1'b1;
                count_nxt = count_r + CW'(1);
              end else begin
                status_nxt = STAT_FULL;
              end
            end
            REQ_RETRIEVE, REQ_DEL_FIRST, REQ_DEL_ALL: begin
              req_nxt   = ukt_req_t'(in_req_type);
              key_nxt   = in_search_key;
              idx_nxt   = '0;
              pend_nxt  = 1'b0;
              found_nxt = 1'b0;
              state_nxt = ST_SCAN;
            end
            REQ_RESET_CURSOR: begin
              cursor_nxt = '0;
              valid_nxt  = 1'b1;
            end
            REQ_GET_NEXT: begin
              if (cursor_r < count_r) begin
                mem_raddr = cursor_r[AW-1:0];
                state_nxt = ST_NEXT;
              end else begin
                status_nxt = STAT_PAST_END;
                valid_nxt  = 1'b1;
              end
            end
            default: begin
              // unused codes: no state change, plain ok result
              valid_nxt = 1'b1;
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (pend_r && (rd_key == key_r)) begin
          found_nxt = 1'b1;
          pend_nxt  = 1'b0;
          if (req_r == REQ_RETRIEVE) begin
            status_nxt = STAT_OK;
            rfound_nxt = 1'b1;
            rkey_nxt   = rd_key;
            rval_nxt   = rd_val;
            valid_nxt  = 1'b1;
            state_nxt  = ST_IDLE;
          end else begin
            // fetch the tail entry to fill the matched slot
            mem_raddr = last[AW-1:0];
            state_nxt = ST_MOVE;
          end
        end else if (idx_r < count_r) begin
          // issue the next read while the previous one is compared
          pend_nxt    = 1'b1;
          cmp_idx_nxt = idx_r[AW-1:0];
          idx_nxt     = idx_r + CW'(1);
        end else if (pend_r) begin
          // last compare done without a match, finish next cycle
          pend_nxt = 1'b0;
        end else begin
          status_nxt = found_r ? STAT_OK : STAT_NOT_FOUND;
          rfound_nxt = found_r;
          rkey_nxt   = '0;
          rval_nxt   = '0;
          valid_nxt  = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end

      ST_MOVE: begin
        // read port holds the tail entry
        if (CW'(cmp_idx_r) < last) begin
          mem_we    = 1'b1;
          mem_waddr = cmp_idx_r;
          mem_wdata = mem_rdata;
        end
        count_nxt = last;
        if (req_r == REQ_DEL_FIRST) begin
          status_nxt = STAT_OK;
          rfound_nxt = 1'b1;
          rkey_nxt   = '0;
          rval_nxt   = '0;
          valid_nxt  = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          // recheck the filled slot and carry on
          idx_nxt   = CW'(cmp_idx_r);
          pend_nxt  = 1'b0;
          state_nxt = ST_SCAN;
        end
      end

      ST_NEXT: begin
        status_nxt = STAT_OK;
        rfound_nxt = 1'b0;
        rkey_nxt   = rd_key;
        rval_nxt   = rd_val;
        cursor_nxt = cursor_r + CW'(1);
        valid_nxt  = 1'b1;
        state_nxt  = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = valid_r;
  assign out_status       = status_r;
  assign out_found        = rfound_r;
  assign out_result_key   = rkey_r;
  assign out_result_value = rval_r;
  // count is final by the time the result is strobed
  assign out_entry_count  = count_r;
  assign out_is_full      = (count_r == CW'(CAPACITY));

endmodule
